// ----- hw/rtl/owhsd_pkg.sv -----
package owhsd_pkg;

	localparam int FRAME_BYTES = 5;
	localparam int FRAME_BITS  = FRAME_BYTES * 8;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_EDGE  = 1'b1;

	localparam logic [2:0] ST_NOT_STARTED = 3'd0;
	localparam logic [2:0] ST_OK          = 3'd1;
	localparam logic [2:0] ST_CHECKSUM    = 3'd2;
	localparam logic [2:0] ST_TIMEOUT     = 3'd3;
	localparam logic [2:0] ST_SHORT       = 3'd4;

	localparam int GAP_TIMEOUT   = 6000;
	localparam int RESP_GLITCH   = 25;
	localparam int RESP_MIN      = 125;
	localparam int RESP_MAX      = 190;
	localparam int BIT_MIN       = 60;
	localparam int BIT_MAX       = 145;
	localparam int BIT_ONE       = 100;
	localparam int BIT_TOO_SHORT = 10;

	localparam logic [2:0] BIT_COUNT_START = 3'd7;

	typedef enum logic [3:0] {
		PH_STOPPED  = 4'b0001,
		PH_RESPONSE = 4'b0010,
		PH_DATA     = 4'b0100,
		PH_DONE     = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [15:0] humidity;
		logic [15:0] temperature;
		logic        sum_ok;
	} reading_t;

endpackage

// ----- hw/rtl/owhsd_frame_dec.sv -----
module owhsd_frame_dec (
	input  logic [owhsd_pkg::FRAME_BITS-1:0] frame,
	input  logic                             sensor_type,
	output owhsd_pkg::reading_t              reading
);

	logic [7:0]  b0, b1, b2, b3, b4;
	logic [15:0] mag;
	logic [7:0]  sum;

	assign b0 = frame[39:32];
	assign b1 = frame[31:24];
	assign b2 = frame[23:16];
	assign b3 = frame[15:8];
	assign b4 = frame[7:0];

	assign mag = {1'b0, b2[6:0], b3};

	always_comb begin
		if (sensor_type) begin
			reading.humidity    = {b0, b1};
			reading.temperature = b2[7] ? 16'(16'd0 - mag) : mag;
			sum                 = 8'(b0 + b1 + b2 + b3);
		end else begin
			reading.humidity    = {8'd0, b0};
			reading.temperature = {8'd0, b2};
			sum                 = 8'(b0 + b2);
		end
		reading.sum_ok = (sum == b4);
	end

endmodule

// ----- hw/rtl/one_wire_humidity_sensor_decoder.sv -----
// Decoder for a single-wire humidity/temperature sensor. Each input transaction is either a
// start request or a falling-edge timestamp in microseconds; each gives exactly one result
// transaction carrying status, busy, start-refused and frame-done flags and the latest
// humidity and temperature readings. Transactions pass an input register and a result
// register, so one is taken every clock cycle while the output side keeps up; out_valid
// comes from the result register, written from the input register when the output side
// can advance. The 40-bit frame is built in a shift register, one bit per qualifying edge
// gap. Write sensor_type only while idle.
module one_wire_humidity_sensor_decoder #(
	parameter int TIME_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [31:0]         time_us,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status_code,
	output logic                busy_res,
	output logic                start_refused,
	output logic                frame_done,
	output logic [15:0]         humidity,
	output logic signed [15:0]  temperature
);

	localparam int FB = owhsd_pkg::FRAME_BITS;

	logic                   sensor_type_q;

	logic                   valid_s1;
	logic                   req_s1;
	logic [31:0]            time_s1;

	owhsd_pkg::phase_t      phase_q, phase_d;
	logic [TIME_BITS-1:0]   last_time_q, last_time_d;
	logic [FB-1:0]          frame_q, frame_d, frame_shift;
	logic [2:0]             bit_cnt_q, bit_cnt_d;
	logic [2:0]             byte_idx_q, byte_idx_d, byte_idx_inc;
	logic [2:0]             status_q, status_d;
	logic [15:0]            hum_q, hum_d;
	logic [15:0]            temp_q, temp_d;
	logic                   refused_d, done_d;

	logic [TIME_BITS-1:0]   now, delta;
	logic                   adv, proc;
	owhsd_pkg::reading_t    reading;

	logic                   out_valid_q;
	logic [2:0]             status_s2;
	logic                   busy_s2, refused_s2, done_s2;
	logic [15:0]            hum_s2, temp_s2;

	generate
		if (TIME_BITS >= 32) begin : g_wide_time
			assign now = TIME_BITS'(time_s1);
		end else begin : g_narrow_time
			assign now = time_s1[TIME_BITS-1:0];
		end
	endgenerate

	assign delta        = TIME_BITS'(now - last_time_q);
	assign frame_shift  = {frame_q[FB-2:0], (delta > TIME_BITS'(owhsd_pkg::BIT_ONE))};
	assign byte_idx_inc = 3'(byte_idx_q + 3'd1);

	assign adv      = ~out_valid_q | ~out_stall;
	assign proc     = valid_s1 & adv;
	assign in_stall = valid_s1 & ~adv;

	owhsd_frame_dec u_frame_dec (
		.frame       (frame_shift),
		.sensor_type (sensor_type_q),
		.reading     (reading)
	);

	always_comb begin
		phase_d     = phase_q;
		last_time_d = last_time_q;
		frame_d     = frame_q;
		bit_cnt_d   = bit_cnt_q;
		byte_idx_d  = byte_idx_q;
		status_d    = status_q;
		hum_d       = hum_q;
		temp_d      = temp_q;
		refused_d   = 1'b0;
		done_d      = 1'b0;

		if (req_s1 == owhsd_pkg::REQ_START) begin
			if (phase_q == owhsd_pkg::PH_STOPPED || phase_q == owhsd_pkg::PH_DONE) begin
				phase_d     = owhsd_pkg::PH_RESPONSE;
				frame_d     = '0;
				bit_cnt_d   = owhsd_pkg::BIT_COUNT_START;
				byte_idx_d  = 3'd0;
				hum_d       = 16'd0;
				temp_d      = 16'd0;
				last_time_d = now;
			end else begin
				refused_d = 1'b1;
			end
		end else if (phase_q == owhsd_pkg::PH_RESPONSE || phase_q == owhsd_pkg::PH_DATA) begin
			last_time_d = now;
			if (delta > TIME_BITS'(owhsd_pkg::GAP_TIMEOUT)) begin
				status_d = owhsd_pkg::ST_TIMEOUT;
				phase_d  = owhsd_pkg::PH_STOPPED;
			end else if (phase_q == owhsd_pkg::PH_RESPONSE) begin
				if (delta < TIME_BITS'(owhsd_pkg::RESP_GLITCH)) begin
					last_time_d = last_time_q;
				end else if (delta > TIME_BITS'(owhsd_pkg::RESP_MIN) &&
						delta < TIME_BITS'(owhsd_pkg::RESP_MAX)) begin
					phase_d = owhsd_pkg::PH_DATA;
				end else begin
					status_d = owhsd_pkg::ST_TIMEOUT;
					phase_d  = owhsd_pkg::PH_STOPPED;
				end
			end else begin
				if (delta > TIME_BITS'(owhsd_pkg::BIT_MIN) &&
						delta < TIME_BITS'(owhsd_pkg::BIT_MAX)) begin
					frame_d = frame_shift;
					if (bit_cnt_q == 3'd0) begin
						bit_cnt_d  = owhsd_pkg::BIT_COUNT_START;
						byte_idx_d = byte_idx_inc;
						if (byte_idx_inc == 3'(owhsd_pkg::FRAME_BYTES)) begin
							done_d = 1'b1;
							hum_d  = reading.humidity;
							temp_d = reading.temperature;
							if (reading.sum_ok) begin
								status_d = owhsd_pkg::ST_OK;
								phase_d  = owhsd_pkg::PH_DONE;
							end else begin
								status_d = owhsd_pkg::ST_CHECKSUM;
								phase_d  = owhsd_pkg::PH_STOPPED;
							end
						end
					end else begin
						bit_cnt_d = 3'(bit_cnt_q - 3'd1);
					end
				end else if (delta < TIME_BITS'(owhsd_pkg::BIT_TOO_SHORT)) begin
					status_d = owhsd_pkg::ST_SHORT;
					phase_d  = owhsd_pkg::PH_STOPPED;
				end else begin
					status_d = owhsd_pkg::ST_TIMEOUT;
					phase_d  = owhsd_pkg::PH_STOPPED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_type_q <= 1'b0;
		end else if (cfg_wr_en) begin
			sensor_type_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1  <= req_type;
			time_s1 <= time_us;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= owhsd_pkg::PH_STOPPED;
			last_time_q <= '0;
			frame_q     <= '0;
			bit_cnt_q   <= owhsd_pkg::BIT_COUNT_START;
			byte_idx_q  <= 3'd0;
			status_q    <= owhsd_pkg::ST_NOT_STARTED;
			hum_q       <= 16'd0;
			temp_q      <= 16'd0;
		end else if (proc) begin
			phase_q     <= phase_d;
			last_time_q <= last_time_d;
			frame_q     <= frame_d;
			bit_cnt_q   <= bit_cnt_d;
			byte_idx_q  <= byte_idx_d;
			status_q    <= status_d;
			hum_q       <= hum_d;
			temp_q      <= temp_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			status_s2  <= status_d;
			busy_s2    <= (phase_d == owhsd_pkg::PH_RESPONSE) ||
				(phase_d == owhsd_pkg::PH_DATA);
			refused_s2 <= refused_d;
			done_s2    <= done_d;
			hum_s2     <= hum_d;
			temp_s2    <= temp_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status_code   = status_s2;
	assign busy_res      = busy_s2;
	assign start_refused = refused_s2;
	assign frame_done    = done_s2;
	assign humidity      = hum_s2;
	assign temperature   = temp_s2;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [2:0]  status;
		logic        busy;
		logic        refused;
		logic        done;
		logic [15:0] hum;
		logic [15:0] temp;
	} sensor_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = owhsd_pkg::REQ_START;
	logic [31:0] time_us = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status_code;
	logic        busy_res;
	logic        start_refused;
	logic        frame_done;
	logic [15:0] humidity;
	logic signed [15:0] temperature;

	// decoder state as the bench sees it
	owhsd_pkg::phase_t dec_phase = owhsd_pkg::PH_STOPPED;
	logic [31:0] dec_last = 32'h0;
	logic [7:0]  dec_bytes [owhsd_pkg::FRAME_BYTES] = '{default: 8'h00};
	logic [2:0]  dec_bits_left = owhsd_pkg::BIT_COUNT_START;
	logic [2:0]  dec_byte_idx = 3'd0;
	logic [2:0]  dec_status = owhsd_pkg::ST_NOT_STARTED;
	logic [15:0] dec_hum = 16'h0;
	logic [15:0] dec_temp = 16'h0;
	logic        fmt_word = 1'b0;

	sensor_report_t reports_due [$];
	logic [31:0] tnow = 32'h0;
	int          items_sent = 0;
	int          errors = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	one_wire_humidity_sensor_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.time_us(time_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status_code(status_code),
		.busy_res(busy_res),
		.start_refused(start_refused),
		.frame_done(frame_done),
		.humidity(humidity),
		.temperature(temperature)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic halt_decoder(input logic [2:0] code);
		dec_status = code;
		dec_phase  = owhsd_pkg::PH_STOPPED;
	endtask

	task automatic close_frame();
		logic [15:0] mag;
		logic [7:0]  sum;
		if (fmt_word) begin
			dec_hum  = {dec_bytes[0], dec_bytes[1]};
			mag      = {1'b0, dec_bytes[2][6:0], dec_bytes[3]};
			dec_temp = dec_bytes[2][7] ? 16'h0 - mag : mag;
			sum      = dec_bytes[0] + dec_bytes[1] + dec_bytes[2] + dec_bytes[3];
		end else begin
			dec_hum  = {8'h00, dec_bytes[0]};
			dec_temp = {8'h00, dec_bytes[2]};
			sum      = dec_bytes[0] + dec_bytes[2];
		end
		if (dec_bytes[4] != sum) begin
			halt_decoder(owhsd_pkg::ST_CHECKSUM);
		end else begin
			dec_status = owhsd_pkg::ST_OK;
			dec_phase  = owhsd_pkg::PH_DONE;
		end
	endtask

	task automatic decode_event(input logic rt, input logic [31:0] t);
		sensor_report_t r;
		logic [31:0] gap;
		r.refused = 1'b0;
		r.done    = 1'b0;
		if (rt == owhsd_pkg::REQ_START) begin
			if (dec_phase == owhsd_pkg::PH_STOPPED || dec_phase == owhsd_pkg::PH_DONE) begin
				dec_phase = owhsd_pkg::PH_RESPONSE;
				dec_bytes = '{default: 8'h00};
				dec_bits_left = owhsd_pkg::BIT_COUNT_START;
				dec_byte_idx = 3'd0;
				dec_hum  = 16'h0;
				dec_temp = 16'h0;
				dec_last = t;
			end else begin
				r.refused = 1'b1;
			end
		end else if (dec_phase == owhsd_pkg::PH_RESPONSE || dec_phase == owhsd_pkg::PH_DATA) begin
			gap = t - dec_last;
			dec_last = t;
			if (gap > owhsd_pkg::GAP_TIMEOUT) begin
				halt_decoder(owhsd_pkg::ST_TIMEOUT);
			end else if (dec_phase == owhsd_pkg::PH_RESPONSE) begin
				if (gap < owhsd_pkg::RESP_GLITCH) begin
					dec_last = t - gap;
				end else if (gap > owhsd_pkg::RESP_MIN && gap < owhsd_pkg::RESP_MAX) begin
					dec_phase = owhsd_pkg::PH_DATA;
				end else begin
					halt_decoder(owhsd_pkg::ST_TIMEOUT);
				end
			end else if (gap > owhsd_pkg::BIT_MIN && gap < owhsd_pkg::BIT_MAX) begin
				if (dec_byte_idx < owhsd_pkg::FRAME_BYTES) begin
					dec_bytes[dec_byte_idx] = {dec_bytes[dec_byte_idx][6:0],
						gap > owhsd_pkg::BIT_ONE};
				end
				if (dec_bits_left == 3'd0) begin
					dec_bits_left = owhsd_pkg::BIT_COUNT_START;
					dec_byte_idx = dec_byte_idx + 3'd1;
					if (dec_byte_idx == owhsd_pkg::FRAME_BYTES) begin
						r.done = 1'b1;
						close_frame();
					end
				end else begin
					dec_bits_left = dec_bits_left - 3'd1;
				end
			end else if (gap < owhsd_pkg::BIT_TOO_SHORT) begin
				halt_decoder(owhsd_pkg::ST_SHORT);
			end else begin
				halt_decoder(owhsd_pkg::ST_TIMEOUT);
			end
		end
		r.status = dec_status;
		r.busy   = (dec_phase == owhsd_pkg::PH_RESPONSE || dec_phase == owhsd_pkg::PH_DATA);
		r.hum    = dec_hum;
		r.temp   = dec_temp;
		reports_due.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_reports
		sensor_report_t e;
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected transaction, status %0h", $time, status_code);
				errors++;
			end else begin
				e = reports_due.pop_front();
				compare_field("status_code", 16'(e.status), 16'(status_code));
				compare_field("busy_res", 16'(e.busy), 16'(busy_res));
				compare_field("start_refused", 16'(e.refused), 16'(start_refused));
				compare_field("frame_done", 16'(e.done), 16'(frame_done));
				compare_field("humidity", e.hum, humidity);
				compare_field("temperature", e.temp, temperature);
			end
		end
	end

	task automatic send_event(input logic rt, input logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		time_us  <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		decode_event(rt, t);
		items_sent++;
	endtask

	task automatic start_at(input logic [31:0] t);
		tnow = t;
		send_event(owhsd_pkg::REQ_START, t);
	endtask

	task automatic edge_after(input logic [31:0] gap);
		tnow = tnow + gap;
		send_event(owhsd_pkg::REQ_EDGE, tnow);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_sensor_type(input logic wide);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= wide;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fmt_word = wide;
	endtask

	function automatic logic [39:0] make_frame(input logic wide);
		logic [7:0] b [owhsd_pkg::FRAME_BYTES];
		logic [7:0] sum;
		for (int i = 0; i < owhsd_pkg::FRAME_BYTES - 1; i++) begin
			case ($urandom_range(7))
				0: b[i] = 8'h00;
				1: b[i] = 8'hFF;
				2: b[i] = 8'h80;
				default: b[i] = 8'($urandom);
			endcase
		end
		sum = wide ? b[0] + b[1] + b[2] + b[3] : b[0] + b[2];
		b[4] = ($urandom_range(4) == 0) ? 8'($urandom) : sum;
		return {b[0], b[1], b[2], b[3], b[4]};
	endfunction

	// start, optional glitches, response, then 40 bits MSB first; may break off early
	task automatic send_frame(input logic [39:0] frame);
		logic [31:0] base;
		send_event(owhsd_pkg::REQ_START, tnow);
		base = tnow;
		repeat ($urandom_range(2)) send_event(owhsd_pkg::REQ_EDGE, base + $urandom_range(24));
		if ($urandom_range(19) == 0) begin
			case ($urandom_range(2))
				0: tnow = tnow + $urandom_range(25, 125);
				1: tnow = tnow + $urandom_range(190, 6000);
				default: tnow = tnow + $urandom_range(6001, 1000000);
			endcase
			send_event(owhsd_pkg::REQ_EDGE, tnow);
			return;
		end
		edge_after($urandom_range(126, 189));
		for (int k = 39; k >= 0; k--) begin
			if ($urandom_range(99) == 0)
				send_event(owhsd_pkg::REQ_START, tnow + $urandom_range(60));
			if ($urandom_range(199) == 0) begin
				case ($urandom_range(4))
					0: tnow = tnow + $urandom_range(9);
					1: tnow = tnow + $urandom_range(10, 60);
					2: tnow = tnow + $urandom_range(145, 6000);
					3: tnow = tnow - $urandom_range(1, 1000);
					default: tnow = tnow + $urandom_range(6001, 32'hFFFF_0000);
				endcase
				send_event(owhsd_pkg::REQ_EDGE, tnow);
				return;
			end
			edge_after(frame[k] ? $urandom_range(101, 144) : $urandom_range(61, 100));
		end
		if ($urandom_range(3) == 0)
			send_event(owhsd_pkg::REQ_EDGE, tnow + $urandom_range(200));
	endtask

	task automatic run_frames(input logic wide);
		int stop_at;
		wait_drained();
		set_sensor_type(wide);
		stop_at = items_sent + 260;
		while (items_sent < stop_at) begin
			tnow = ($urandom_range(9) == 0) ? $urandom : tnow + $urandom_range(200, 2000000);
			send_frame(make_frame(wide));
		end
	endtask

	task automatic test_gap_checks();
		send_event(owhsd_pkg::REQ_EDGE, 32'hFFFF_FFFF);
		start_at(32'h0000_0000);
		send_event(owhsd_pkg::REQ_START, 32'h0000_0005);
		send_event(owhsd_pkg::REQ_EDGE, tnow);
		send_event(owhsd_pkg::REQ_EDGE, tnow + 24);
		edge_after(25);
		start_at(32'hFFFF_FFC0);
		edge_after(126);
		edge_after(61);
		edge_after(100);
		edge_after(101);
		edge_after(144);
		edge_after(145);
		start_at(tnow + 5000);
		edge_after(189);
		edge_after(60);
		start_at(tnow + 7);
		edge_after(126);
		edge_after(9);
		start_at(tnow + 3);
		edge_after(150);
		edge_after(10);
		start_at(tnow + 40);
		edge_after(190);
		start_at(tnow + 40);
		edge_after(125);
		start_at(tnow + 40);
		edge_after(6001);
		start_at(tnow + 40);
		edge_after(150);
		edge_after(6001);
		start_at(32'h7FFF_FFFF);
		edge_after(32'hFFFF_FFFB); // five back
	endtask

	task automatic test_byte_frames();
		run_frames(1'b0);
	endtask

	task automatic test_word_frames();
		run_frames(1'b1);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_gap_checks();
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 33 : (p == 1) ? 68 : 0;
			recv_idle_pct = (p == 0) ? 68 : (p == 1) ? 33 : 0;
			test_word_frames();
			test_byte_frames();
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
